### design/vkts_pkg.sv
// Package for the vector keyframe track sampler.
// Holds the transfer structs, function and status codes, and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vkts_pkg;

   localparam logic [1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [1:0] FUNC_APPEND = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;
   localparam logic [1:0] STATUS_ACK   = 2'd3;

   localparam int FRAC_BITS = 16;

   typedef struct packed {
      logic        [1:0]  func;
      logic signed [31:0] time_point;
      logic signed [31:0] key_x;
      logic signed [31:0] key_y;
      logic signed [31:0] key_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic        [1:0]  status;
      logic        [5:0]  segment;
      logic        [16:0] blend;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_FETCH0,
      ST_FETCH1,
      ST_FETCH2,
      ST_BLEND,
      ST_DIV,
      ST_MUL,
      ST_ADD,
      ST_DONE
   } state_type;

endpackage
`default_nettype wire

### design/vector_keyframe_track_sampler.sv
// Top level of the vector keyframe track sampler: key store, scan, divider, mixer.
// Depends on vkts_pkg.
//
// channel | direction | handshake                    | payload
// req     | in        | req_valid / req_stall        | req_type
// rsp     | out       | rsp_valid / rsp_stall        | rsp_type
//
// Clear, append and unused codes finish in the transfer cycle. A sample over two or more keys
// runs the key time scan, then the blend divider when the blend is a proper fraction,
// then the shared multiplier and adder once for each of the three components.
// Reset empties the track; the key memories are never cleared.
// A result waits in the output register; while it is stalled no new item is taken.
`timescale 1ns / 1ps
`default_nettype none
module vector_keyframe_track_sampler
   import vkts_pkg::*;
#(
   parameter int MAX_KEYS = 64
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
   localparam int CW = $clog2(MAX_KEYS + 1);
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_KEYS);

   logic signed [31:0] time_mem [MAX_KEYS];
   logic        [95:0] vec_mem  [MAX_KEYS];
   logic signed [31:0] time_rd_ff;
   logic        [95:0] vec_rd_ff;

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff;
   logic [IW-1:0] scan_ff, seg_ff;
   logic          single_ff;
   logic signed [31:0] t_ff, t0_ff, t1_ff;
   logic signed [31:0] a_ff [3];
   logic signed [31:0] b_ff [3];
   logic signed [31:0] res_ff [3];
   logic [16:0] blend_ff;
   logic [33:0] rem_ff;
   logic [32:0] ag_ff;
   logic [15:0] quo_ff;
   logic [3:0]  div_cnt_ff;
   logic [1:0]  comp_ff;
   logic signed [49:0] prod_ff;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;
   rsp_type rsp_data_in;
   logic    rsp_load;

   logic          accept, slot_free, scan_hit, mem_write;
   logic [IW-1:0] time_addr, vec_addr;
   logic [CW-1:0] last_idx;
   logic signed [32:0] num, gap, diff;
   logic [32:0] an, ag;
   logic [33:0] rem_shift;
   logic signed [34:0] mix_sum;
   logic signed [31:0] mix_sat;
   logic [IW+5:0] seg_wide;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign last_idx  = count_ff - 1'b1;
   assign scan_hit  = (t_ff < time_rd_ff) || (CW'(scan_ff) == last_idx);
   assign num       = {t_ff[31], t_ff} - {t0_ff[31], t0_ff};
   assign gap       = {t1_ff[31], t1_ff} - {t0_ff[31], t0_ff};
   assign an        = num[32] ? -num : num;
   assign ag        = gap[32] ? -gap : gap;
   assign rem_shift = {rem_ff[32:0], 1'b0};
   assign diff      = {b_ff[comp_ff][31], b_ff[comp_ff]} - {a_ff[comp_ff][31], a_ff[comp_ff]};
   assign mix_sum   = 35'(a_ff[comp_ff])
                    + 35'((prod_ff + 50'sd32768) >>> FRAC_BITS);
   assign seg_wide  = {6'd0, seg_ff};
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      if (mix_sum > 35'sd2147483647) begin
         mix_sat = 32'sh7fffffff;
      end else if (mix_sum < -35'sd2147483648) begin
         mix_sat = 32'sh80000000;
      end else begin
         mix_sat = mix_sum[31:0];
      end
   end

   always_comb begin
      req_stall = (state_ff != ST_IDLE) || !slot_free;
      mem_write = accept && (req_data.func == FUNC_APPEND) && (count_ff < MAX_COUNT);
      time_addr = scan_ff;
      vec_addr  = seg_ff;
      case (state_ff)
         ST_FETCH0: begin
            time_addr = seg_ff;
            vec_addr  = seg_ff;
         end
         ST_FETCH1: vec_addr = seg_ff + 1'b1;
         default: begin
            time_addr = scan_ff;
            vec_addr  = seg_ff;
         end
      endcase
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in.status = STATUS_ACK;
      rsp_load           = 1'b0;
      if (state_ff == ST_DONE) begin
         rsp_data_in.out_x   = res_ff[0];
         rsp_data_in.out_y   = res_ff[1];
         rsp_data_in.out_z   = res_ff[2];
         rsp_data_in.status  = STATUS_OK;
         rsp_data_in.segment = seg_wide[5:0];
         rsp_data_in.blend   = blend_ff;
         rsp_load            = slot_free;
      end else if (accept) begin
         case (req_data.func)
            FUNC_APPEND: begin
               if (count_ff >= MAX_COUNT) begin
                  rsp_data_in.status = STATUS_FULL;
               end
               rsp_load = 1'b1;
            end
            FUNC_SAMPLE: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = STATUS_EMPTY;
                  rsp_load           = 1'b1;
               end
            end
            default: rsp_load = 1'b1;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_data.func == FUNC_SAMPLE) && (count_ff != '0)) begin
               state_in = (count_ff == CW'(1)) ? ST_FETCH0 : ST_SCAN_RD;
            end
         end
         ST_SCAN_RD:  state_in = ST_SCAN_CMP;
         ST_SCAN_CMP: state_in = scan_hit ? ST_FETCH0 : ST_SCAN_RD;
         ST_FETCH0:   state_in = ST_FETCH1;
         ST_FETCH1:   state_in = single_ff ? ST_DONE : ST_FETCH2;
         ST_FETCH2:   state_in = ST_BLEND;
         ST_BLEND: begin
            if (gap == '0 || num == '0 || (num[32] != gap[32]) || an >= ag) begin
               state_in = ST_MUL;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV:  state_in = (div_cnt_ff == 4'd0) ? ST_MUL : ST_DIV;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD:  state_in = (comp_ff == 2'd2) ? ST_DONE : ST_MUL;
         ST_DONE: state_in = slot_free ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         time_mem[count_ff[IW-1:0]] <= req_data.time_point;
         vec_mem[count_ff[IW-1:0]]  <= {req_data.key_z, req_data.key_y, req_data.key_x};
      end
      time_rd_ff <= time_mem[time_addr];
      vec_rd_ff  <= vec_mem[vec_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= rsp_data_in;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (accept && (req_data.func == FUNC_CLEAR)) begin
            count_ff <= '0;
         end else if (mem_write) begin
            count_ff <= count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            t_ff      <= req_data.time_point;
            scan_ff   <= IW'(1);
            seg_ff    <= '0;
            single_ff <= (count_ff == CW'(1));
            comp_ff   <= 2'd0;
            blend_ff  <= '0;
         end
         ST_SCAN_CMP: begin
            if (scan_hit) begin
               seg_ff <= scan_ff - 1'b1;
               t1_ff  <= time_rd_ff;
            end else begin
               scan_ff <= scan_ff + 1'b1;
            end
         end
         ST_FETCH1: begin
            t0_ff     <= time_rd_ff;
            a_ff[0]   <= vec_rd_ff[31:0];
            a_ff[1]   <= vec_rd_ff[63:32];
            a_ff[2]   <= vec_rd_ff[95:64];
            res_ff[0] <= vec_rd_ff[31:0];
            res_ff[1] <= vec_rd_ff[63:32];
            res_ff[2] <= vec_rd_ff[95:64];
         end
         ST_FETCH2: begin
            b_ff[0] <= vec_rd_ff[31:0];
            b_ff[1] <= vec_rd_ff[63:32];
            b_ff[2] <= vec_rd_ff[95:64];
         end
         ST_BLEND: begin
            rem_ff     <= {1'b0, an};
            ag_ff      <= ag;
            quo_ff     <= '0;
            div_cnt_ff <= 4'd15;
            if (gap == '0 || num == '0 || (num[32] != gap[32])) begin
               blend_ff <= '0;
            end else if (an >= ag) begin
               blend_ff <= 17'd65536;
            end
         end
         ST_DIV: begin
            if (rem_shift >= {1'b0, ag_ff}) begin
               rem_ff <= rem_shift - {1'b0, ag_ff};
               quo_ff <= {quo_ff[14:0], 1'b1};
            end else begin
               rem_ff <= rem_shift;
               quo_ff <= {quo_ff[14:0], 1'b0};
            end
            div_cnt_ff <= div_cnt_ff - 1'b1;
            if (div_cnt_ff == 4'd0) begin
               blend_ff <= {1'b0, quo_ff[14:0], (rem_shift >= {1'b0, ag_ff})};
            end
         end
         ST_MUL: prod_ff <= 50'(diff) * 50'($signed({1'b0, blend_ff}));
         ST_ADD: begin
            res_ff[comp_ff] <= mix_sat;
            comp_ff         <= comp_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the vector keyframe track sampler: random and directed loads and samples.
// A scoreboard class predicts each result from its own copy of the key track and checks it.
// Depends on vkts_pkg and vector_keyframe_track_sampler.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import vkts_pkg::*;

   localparam int TRACK_DEPTH = 64;
   localparam logic [1:0] FUNC_SPARE = 2'd3;

   class track_scoreboard;
      logic signed [31:0] times_q[TRACK_DEPTH];
      logic signed [31:0] vx_q[TRACK_DEPTH];
      logic signed [31:0] vy_q[TRACK_DEPTH];
      logic signed [31:0] vz_q[TRACK_DEPTH];
      int unsigned stored;
      rsp_type pending[$];
      int errors;

      function new();
         stored = 0;
         errors = 0;
      endfunction

      function logic [16:0] blend_factor(longint t, longint t0, longint t1);
         longint num;
         longint gap;
         longint an;
         longint ag;
         num = t - t0;
         gap = t1 - t0;
         if (gap == 0 || num == 0) return 17'd0;
         if ((num < 0) != (gap < 0)) return 17'd0;
         an = num < 0 ? -num : num;
         ag = gap < 0 ? -gap : gap;
         if (an >= ag) return 17'd65536;
         return 17'((an << 16) / ag);
      endfunction

      function logic signed [31:0] lerp(longint a, longint b, logic [16:0] f);
         longint prod;
         longint r;
         prod = (b - a) * longint'(f) + 32768;
         r = a + (prod >>> 16);
         if (r > 64'sd2147483647) r = 64'sd2147483647;
         if (r < -64'sd2147483648) r = -64'sd2147483648;
         return r[31:0];
      endfunction

      function void note_request(req_type rq);
         rsp_type e;
         int unsigned seg;
         logic [16:0] f;
         e = '0;
         e.status = STATUS_ACK;
         if (rq.func == FUNC_CLEAR) begin
            stored = 0;
         end else if (rq.func == FUNC_APPEND) begin
            if (stored >= TRACK_DEPTH) begin
               e.status = STATUS_FULL;
            end else begin
               times_q[stored] = rq.time_point;
               vx_q[stored] = rq.key_x;
               vy_q[stored] = rq.key_y;
               vz_q[stored] = rq.key_z;
               stored++;
            end
         end else if (rq.func == FUNC_SAMPLE) begin
            if (stored == 0) begin
               e.status = STATUS_EMPTY;
            end else if (stored == 1) begin
               e.status = STATUS_OK;
               e.out_x = vx_q[0];
               e.out_y = vy_q[0];
               e.out_z = vz_q[0];
            end else begin
               e.status = STATUS_OK;
               seg = stored - 2;
               for (int i = 0; i + 1 < stored; i++) begin
                  if (rq.time_point < times_q[i + 1]) begin
                     seg = i;
                     break;
                  end
               end
               f = blend_factor(rq.time_point, times_q[seg], times_q[seg + 1]);
               e.out_x = lerp(vx_q[seg], vx_q[seg + 1], f);
               e.out_y = lerp(vy_q[seg], vy_q[seg + 1], f);
               e.out_z = lerp(vz_q[seg], vz_q[seg + 1], f);
               e.segment = 6'(seg);
               e.blend = f;
            end
         end
         pending = {pending, e};
      endfunction

      function void check_result(rsp_type got);
         rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no expectation: %p", got);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.out_x !== e.out_x) begin
            $error("out_x expected %0d actual %0d", e.out_x, got.out_x); errors++;
         end
         if (got.out_y !== e.out_y) begin
            $error("out_y expected %0d actual %0d", e.out_y, got.out_y); errors++;
         end
         if (got.out_z !== e.out_z) begin
            $error("out_z expected %0d actual %0d", e.out_z, got.out_z); errors++;
         end
         if (got.status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, got.status); errors++;
         end
         if (got.segment !== e.segment) begin
            $error("segment expected %0d actual %0d", e.segment, got.segment); errors++;
         end
         if (got.blend !== e.blend) begin
            $error("blend expected %0d actual %0d", e.blend, got.blend); errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   track_scoreboard board = new();
   bit quiet_tail = 1'b0;
   bit hold_rsp = 1'b0;
   int unsigned sent = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   vector_keyframe_track_sampler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) board.note_request(req_data);
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || quiet_tail) begin
         rsp_stall <= 1'b0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      @(posedge clock);
      wait (sent > 300);
      @(posedge clock);
      hold_rsp = 1'b1;
      repeat (2000) @(posedge clock);
      hold_rsp = 1'b0;
   end

   function logic signed [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2: return 32'(int'($urandom_range(0, 2000)) - 1000);
         default: return $urandom();
      endcase
   endfunction

   task automatic send(logic [1:0] func, logic signed [31:0] tp,
                       logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z);
      req_type rq;
      rq.func = func;
      rq.time_point = tp;
      rq.key_x = x;
      rq.key_y = y;
      rq.key_z = z;
      if (!quiet_tail && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic send_random_track(int unsigned n, bit sorted);
      logic signed [31:0] tk;
      tk = 32'(int'($urandom_range(0, 200000)) - 100000);
      send(FUNC_CLEAR, $urandom(), $urandom(), $urandom(), $urandom());
      for (int i = 0; i < n; i++) begin
         send(FUNC_APPEND, sorted ? tk : rand_word(), rand_word(), rand_word(), rand_word());
         tk = tk + ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 200000));
      end
   endtask

   initial begin
      logic [1:0] fn;
      int unsigned n;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(FUNC_SAMPLE, 32'sd0, '0, '0, '0);
      send(FUNC_SPARE, 32'sh7fffffff, '1, '1, '1);
      send(FUNC_APPEND, 32'sd65536, 32'sh7fffffff, 32'sh80000000, 32'sd5);
      send(FUNC_SAMPLE, 32'sh80000000, '0, '0, '0);
      send(FUNC_APPEND, 32'sd65536, 32'sh80000000, 32'sh7fffffff, 32'sd7);
      send(FUNC_SAMPLE, 32'sd65536, '0, '0, '0);
      send(FUNC_APPEND, 32'sd131072, 32'sh7fffffff, 32'sh80000000, -32'sd3);
      send(FUNC_SAMPLE, 32'sd98304, '0, '0, '0);
      send(FUNC_SAMPLE, 32'sh7fffffff, '0, '0, '0);
      send(FUNC_SAMPLE, 32'sh80000000, '0, '0, '0);
      send(FUNC_APPEND, 32'sd0, 32'sd1, 32'sd2, 32'sd3);
      send(FUNC_SAMPLE, 32'sd100000, '0, '0, '0);
      send_random_track(TRACK_DEPTH + 2, 1'b1);
      send(FUNC_SAMPLE, 32'sh7fffffff, '0, '0, '0);
      send(FUNC_SAMPLE, 32'sh80000000, '0, '0, '0);
      send(FUNC_CLEAR, '0, '0, '0, '0);
      send(FUNC_SAMPLE, 32'sd1, '0, '0, '0);

      while (sent < 1950) begin
         n = $urandom_range(0, 9) == 0 ? $urandom_range(40, TRACK_DEPTH + 3)
                                        : $urandom_range(0, 8);
         if (sent > 1700) quiet_tail = 1'b1;
         send_random_track(n, $urandom_range(0, 4) != 0);
         repeat ($urandom_range(2, 12)) begin
            fn = $urandom_range(0, 19) == 0 ? 2'($urandom_range(0, 3)) : FUNC_SAMPLE;
            send(fn, $urandom_range(0, 1) ? rand_word()
                     : 32'(int'($urandom_range(0, 2000000)) - 500000),
                 $urandom(), $urandom(), $urandom());
         end
      end
      req_valid <= 1'b0;
      quiet_tail = 1'b1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0) begin
         $display("[vector_keyframe_track_sampler] OK");
      end else begin
         $display("[vector_keyframe_track_sampler] ERROR");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("[vector_keyframe_track_sampler] ERROR");
      $finish;
   end

endmodule
`default_nettype wire

### filelist.f
design/vkts_pkg.sv
design/vector_keyframe_track_sampler.sv
tb/testbench.sv
